@@ design/gle_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gle_pkg;

  localparam int MAX_ROUNDS = 40;
  localparam int ROUND_W    = 6;

  typedef struct packed {
    logic        opcode;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic        last_block;
  } block_t;

  typedef struct packed {
    logic [63:0] cipher_low;
    logic [63:0] cipher_high;
    logic        last_out;
  } result_t;

  // what travels down the round pipeline alongside the valid bit
  typedef struct packed {
    logic [127:0] state;
    logic [127:0] key;
    logic         last;
  } stage_t;

  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1
  } reg_index_t;

  typedef enum logic {
    OP_PLAIN   = 1'b0,
    OP_COUNTER = 1'b1
  } opcode_t;

  localparam logic [3:0] SBOX [16] = '{
    4'h1, 4'hA, 4'h4, 4'hC, 4'h6, 4'hF, 4'h3, 4'h9,
    4'h2, 4'hD, 4'hB, 4'h7, 4'h5, 4'h0, 4'h8, 4'hE
  };

  localparam logic [6:0] PERM [128] = '{
    7'd0,  7'd33, 7'd66, 7'd99,  7'd96,  7'd1,  7'd34, 7'd67,
    7'd64, 7'd97, 7'd2,  7'd35,  7'd32,  7'd65, 7'd98, 7'd3,
    7'd4,  7'd37, 7'd70, 7'd103, 7'd100, 7'd5,  7'd38, 7'd71,
    7'd68, 7'd101, 7'd6, 7'd39,  7'd36,  7'd69, 7'd102, 7'd7,
    7'd8,  7'd41, 7'd74, 7'd107, 7'd104, 7'd9,  7'd42, 7'd75,
    7'd72, 7'd105, 7'd10, 7'd43, 7'd40,  7'd73, 7'd106, 7'd11,
    7'd12, 7'd45, 7'd78, 7'd111, 7'd108, 7'd13, 7'd46, 7'd79,
    7'd76, 7'd109, 7'd14, 7'd47, 7'd44,  7'd77, 7'd110, 7'd15,
    7'd16, 7'd49, 7'd82, 7'd115, 7'd112, 7'd17, 7'd50, 7'd83,
    7'd80, 7'd113, 7'd18, 7'd51, 7'd48,  7'd81, 7'd114, 7'd19,
    7'd20, 7'd53, 7'd86, 7'd119, 7'd116, 7'd21, 7'd54, 7'd87,
    7'd84, 7'd117, 7'd22, 7'd55, 7'd52,  7'd85, 7'd118, 7'd23,
    7'd24, 7'd57, 7'd90, 7'd123, 7'd120, 7'd25, 7'd58, 7'd91,
    7'd88, 7'd121, 7'd26, 7'd59, 7'd56,  7'd89, 7'd122, 7'd27,
    7'd28, 7'd61, 7'd94, 7'd127, 7'd124, 7'd29, 7'd62, 7'd95,
    7'd92, 7'd125, 7'd30, 7'd63, 7'd60,  7'd93, 7'd126, 7'd31
  };

  localparam logic [5:0] RCON [MAX_ROUNDS] = '{
    6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B, 6'h37, 6'h2F,
    6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E, 6'h1D, 6'h3A, 6'h35, 6'h2B,
    6'h16, 6'h2C, 6'h18, 6'h30, 6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E,
    6'h1C, 6'h38, 6'h31, 6'h23, 6'h06, 6'h0D, 6'h1B, 6'h36, 6'h2D, 6'h1A
  };

  function automatic logic [127:0] sub_cells(input logic [127:0] x);
    logic [127:0] y;
    y = '0;
    for (int n = 0; n < 32; n++) begin
      y[4*n +: 4] = SBOX[x[4*n +: 4]];
    end
    return y;
  endfunction

  function automatic logic [127:0] perm_bits(input logic [127:0] x);
    logic [127:0] y;
    y = '0;
    for (int i = 0; i < 128; i++) begin
      y[PERM[i]] = x[i];
    end
    return y;
  endfunction

  // constant index wraps at the table length
  function automatic logic [5:0] round_const(input logic [ROUND_W-1:0] idx);
    logic [ROUND_W-1:0] k;
    k = (idx < ROUND_W'(MAX_ROUNDS)) ? idx : idx - ROUND_W'(MAX_ROUNDS);
    return RCON[k];
  endfunction

endpackage
`default_nettype wire

@@ design/gle_round.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gle_round (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire gle_pkg::stage_t             in_stage,
  input  wire logic [gle_pkg::ROUND_W-1:0] round_idx,
  output logic                             out_valid,
  output gle_pkg::stage_t                  out_stage
);
  import gle_pkg::*;

  stage_t stage_next;
  logic [127:0] mixed;
  logic [7:0]   key_tweak;

  always_comb begin
    mixed = perm_bits(sub_cells(in_stage.state)) ^ in_stage.key;
    mixed[127:122] = mixed[127:122];
    mixed[127:120] = mixed[127:120] ^ {2'b00, round_const(round_idx)};
    key_tweak = 8'(round_idx) + 8'd1;
    stage_next.state = mixed;
    // key rotates down a byte, round number plus one XORed into byte 0
    stage_next.key = {in_stage.key[7:0], in_stage.key[127:8]} ^ {120'd0, key_tweak};
    stage_next.last = in_stage.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_stage <= stage_next;
  end

endmodule
`default_nettype wire

@@ design/gift_like_block_encrypt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// done rises once the accepted block has passed the input register and every round register
// throughput: one block per cycle; one input register then one register stage per round
// busy is only high during reset; the receiver cannot stall, results leave on done
// reset clears the pipeline valid bits and both key registers
module gift_like_block_encrypt #(
  parameter int ROUNDS = gle_pkg::MAX_ROUNDS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire gle_pkg::block_t  block,
  output logic                  done,
  output gle_pkg::result_t      result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [63:0]      cfg_data
);
  import gle_pkg::*;

  logic [63:0] key_low;
  logic [63:0] key_high;
  logic        accept;

  logic   valid [ROUNDS+1];
  stage_t stage [ROUNDS+1];

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: counter mode clears the upper half
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stage[0].state <= {(block.opcode == OP_COUNTER) ? 64'd0 : block.block_high,
                       block.block_low};
    stage[0].key   <= {key_high, key_low};
    stage[0].last  <= block.last_block;
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    gle_round u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[r]),
      .in_stage  (stage[r]),
      .round_idx (ROUND_W'(r)),
      .out_valid (valid[r+1]),
      .out_stage (stage[r+1])
    );
  end

  assign done               = valid[ROUNDS];
  assign result.cipher_low  = stage[ROUNDS].state[63:0];
  assign result.cipher_high = stage[ROUNDS].state[127:64];
  assign result.last_out    = stage[ROUNDS].last;

  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(ROUNDS+1) done)
    else $error("accepted block did not come out");

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, ROUNDS+1))
    else $error("result beat with no matching accept");

  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> result.last_out == $past(block.last_block, ROUNDS+1))
    else $error("last marker out of step with its block");

endmodule
`default_nettype wire
